@@ src/tmaa_pkg.sv @@
// ----------------------------------------------------------------------------
// tmaa_pkg
// shared constants and types of the triangle mesh area accumulator
// ----------------------------------------------------------------------------
package tmaa_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int AREA_BITS      = 50;
	localparam int TOTAL_BITS     = 64;
	localparam int RAD_BITS       = 128;
	localparam int ROOT_BITS      = 64;

	localparam logic [1:0] MODE_LIST  = 2'd0;
	localparam logic [1:0] MODE_STRIP = 2'd1;

	// request from sequencer to the shared root unit
	typedef struct packed {
		logic                start;
		logic [RAD_BITS-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic                 done;
		logic [ROOT_BITS-1:0] root;
	} sqrt_rsp_t;

endpackage

@@ src/tmaa_sqrt.sv @@
// ----------------------------------------------------------------------------
// tmaa_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module tmaa_sqrt import tmaa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	// restoring digit recurrence: two radicand bits per step
	logic [RAD_BITS-1:0]  rem_q;
	logic [RAD_BITS-1:0]  src_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [6:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RAD_BITS+1:0]  trial;
	logic [RAD_BITS+1:0]  cur;

	always_comb begin
		cur   = {rem_q, src_q[RAD_BITS-1 -: 2]};
		trial = {{(RAD_BITS-ROOT_BITS){1'b0}}, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(ROOT_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			src_q  <= req.radicand;
			root_q <= '0;
		end else if (busy_q) begin
			src_q <= {src_q[RAD_BITS-3:0], 2'b00};
			if (cur >= trial) begin
				rem_q  <= RAD_BITS'(cur - trial);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= RAD_BITS'(cur);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, root: root_q};

endmodule

@@ src/triangle_mesh_area_accumulator.sv @@
// ----------------------------------------------------------------------------
// triangle_mesh_area_accumulator
// heron area of streamed mesh triangles with a saturating running total
// ----------------------------------------------------------------------------
// Every vertex gives one result item. A vertex that closes no triangle passes
// from idle through the hold update to the output; one with an ignored mode
// goes straight to the output. A closing vertex runs, per edge, three
// squaring steps on one 32x32 multiplier and a pass of the shared root unit
// (64 steps plus start and done), then one perimeter step, 24 partial
// products of 32x32 on the same multiplier for the radicand, one check step
// and a fourth root for the Heron radicand; then the hold and the total are
// updated and the output is written. When floored lengths break the
// triangle inequality the last root is skipped. s_tready is high only while
// the block is idle; the result waits in an output register, so the next
// vertex is taken while it waits and only a result that is still unaccepted
// when the next one is ready stalls the block.
module triangle_mesh_area_accumulator import tmaa_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// coord_x, coord_y, coord_z, padded to bytes
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// prim_mode, first_vertex
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// triangle_area, total_area, padded
	output logic [119:0]        m_tdata,
	// area_valid
	output logic                m_tuser
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DIFF  = 10'b0000000010,
		S_SQ    = 10'b0000000100,
		S_ROOT  = 10'b0000001000,
		S_PERIM = 10'b0000010000,
		S_MUL   = 10'b0000100000,
		S_RROOT = 10'b0001000000,
		S_FIN   = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_WAIT  = 10'b1000000000
	} state_t;

	state_t state_q;

	// held vertices
	logic signed [COORD_BITS-1:0] hv_q [6];
	logic signed [COORD_BITS-1:0] cur_q [3];
	logic [1:0] cnt_q;
	logic [1:0] mode_q;
	logic [TOTAL_BITS-1:0] total_q;

	// edge work
	logic [1:0]  edge_q;          // which edge
	logic [1:0]  axis_q;          // which axis
	logic [COORD_BITS:0] mag_q;
	logic [RAD_BITS-1:0] sqsum_q;
	logic [ROOT_BITS-1:0] len_q [3];
	logic [ROOT_BITS-1:0] fac_q [4];
	logic neg_q;

	// wide product: acc (128) times factor (64), in 32-bit limbs
	logic [RAD_BITS-1:0] prod_q;
	logic [RAD_BITS+63:0] nacc_q;
	logic [RAD_BITS+63:0] nacc_nx;
	logic [1:0] fidx_q;           // factor being applied
	logic [2:0] limb_q;           // partial product index
	logic [31:0] ma, mb;
	logic [63:0] mp;

	logic [AREA_BITS-1:0] area_q;
	logic vld_q;

	logic sq_start_q;
	sqrt_req_t sreq;
	sqrt_rsp_t srsp;

	tmaa_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sreq), .rsp(srsp));

	// edge endpoints: a=(v0,v1) b=(v1,cur) c=(v0,cur)
	logic signed [COORD_BITS-1:0] pa, pb;
	always_comb begin
		unique case (edge_q)
			2'd0: begin
				pa = hv_q[{1'b0, axis_q}];
				pb = hv_q[3'd3 + {1'b0, axis_q}];
			end
			2'd1: begin
				pa = hv_q[3'd3 + {1'b0, axis_q}];
				pb = cur_q[axis_q];
			end
			default: begin
				pa = hv_q[{1'b0, axis_q}];
				pb = cur_q[axis_q];
			end
		endcase
	end

	logic signed [COORD_BITS:0] diff;
	assign diff = {pa[COORD_BITS-1], pa} - {pb[COORD_BITS-1], pb};

	// the one multiplier, shared between squaring and the radicand product
	always_comb begin
		if (state_q == S_SQ) begin
			ma = 32'(mag_q);
			mb = 32'(mag_q);
		end else begin
			ma = prod_q[32*limb_q[1:0] +: 32];
			mb = fac_q[fidx_q][32*limb_q[2] +: 32];
		end
	end
	assign mp = ma * mb;

	// running sum of the partial products of one factor
	assign nacc_nx = nacc_q + ((RAD_BITS+64)'(mp) <<
		(32*(32'(limb_q[1:0]) + 32'(limb_q[2]))));

	logic [ROOT_BITS+1:0] perim;
	assign perim = {2'b0, len_q[0]} + {2'b0, len_q[1]} + {2'b0, len_q[2]};

	assign s_tready = (state_q == S_IDLE);
	// start is registered, so the radicand is chosen by the waiting state
	assign sreq = '{start: sq_start_q,
		radicand: (state_q == S_RROOT) ? prod_q : sqsum_q};

	logic [TOTAL_BITS:0] tsum;
	assign tsum = {1'b0, total_q} + {{(TOTAL_BITS-AREA_BITS+1){1'b0}}, area_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			total_q    <= '0;
			m_tvalid   <= 1'b0;
			sq_start_q <= 1'b0;
			for (int i = 0; i < 6; i++) hv_q[i] <= '0;
		end else begin
			sq_start_q <= 1'b0;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					cur_q[0] <= s_tdata[COORD_BITS-1:0];
					cur_q[1] <= s_tdata[2*COORD_BITS-1:COORD_BITS];
					cur_q[2] <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
					mode_q   <= s_tuser[1:0];
					area_q   <= '0;
					vld_q    <= 1'b0;
					if (s_tuser[1]) state_q <= S_OUT;
					else begin
						if (s_tuser[2]) cnt_q <= '0;
						if (!s_tuser[2] && cnt_q >= 2'd2) begin
							edge_q  <= '0;
							axis_q  <= '0;
							sqsum_q <= '0;
							state_q <= S_DIFF;
						end else state_q <= S_FIN;
					end
				end
				S_DIFF: begin
					mag_q   <= diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
					state_q <= S_SQ;
				end
				S_SQ: begin
					sqsum_q <= sqsum_q + RAD_BITS'(mp);
					if (axis_q == 2'd2) begin
						sq_start_q <= 1'b1;
						state_q    <= S_ROOT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_DIFF;
					end
				end
				S_ROOT: if (srsp.done) begin
					len_q[edge_q] <= srsp.root;
					if (edge_q == 2'd2) state_q <= S_PERIM;
					else begin
						edge_q  <= edge_q + 2'd1;
						axis_q  <= '0;
						sqsum_q <= '0;
						state_q <= S_DIFF;
					end
				end
				S_PERIM: begin
					neg_q <= (perim < {1'b0, len_q[0], 1'b0}) ||
						(perim < {1'b0, len_q[1], 1'b0}) ||
						(perim < {1'b0, len_q[2], 1'b0});
					fac_q[0] <= ROOT_BITS'(perim);
					fac_q[1] <= ROOT_BITS'(perim - {1'b0, len_q[0], 1'b0});
					fac_q[2] <= ROOT_BITS'(perim - {1'b0, len_q[1], 1'b0});
					fac_q[3] <= ROOT_BITS'(perim - {1'b0, len_q[2], 1'b0});
					prod_q  <= {{(RAD_BITS-ROOT_BITS){1'b0}}, ROOT_BITS'(perim)};
					fidx_q  <= 2'd1;
					limb_q  <= '0;
					nacc_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					// accumulate one 32x32 partial product per cycle
					if (limb_q == 3'd7) begin
						// a product past 128 bits saturates, a zero factor clears it
						if (nacc_nx[RAD_BITS+63:RAD_BITS] != '0)
							prod_q <= '1;
						else prod_q <= nacc_nx[RAD_BITS-1:0];
						nacc_q <= '0;
						limb_q <= '0;
						if (fidx_q == 2'd3) state_q <= S_WAIT;
						else fidx_q <= fidx_q + 2'd1;
					end else begin
						nacc_q <= nacc_nx;
						limb_q <= limb_q + 3'd1;
					end
				end
				S_WAIT: begin
					if (neg_q) begin
						area_q  <= '0;
						vld_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						sq_start_q <= 1'b1;
						state_q    <= S_RROOT;
					end
				end
				S_RROOT: if (srsp.done) begin
					area_q  <= (srsp.root[ROOT_BITS-1:2] > (ROOT_BITS-2)'({AREA_BITS{1'b1}}))
						? '1 : AREA_BITS'(srsp.root[ROOT_BITS-1:2]);
					vld_q   <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (vld_q) begin
						total_q <= tsum[TOTAL_BITS] ? '1 : tsum[TOTAL_BITS-1:0];
						if (mode_q == MODE_LIST) cnt_q <= '0;
						else begin
							for (int i = 0; i < 3; i++) begin
								hv_q[i]   <= hv_q[3+i];
								hv_q[3+i] <= cur_q[i];
							end
						end
					end else begin
						for (int i = 0; i < 3; i++) hv_q[3*cnt_q[0]+i] <= cur_q[i];
						cnt_q <= cnt_q + 2'd1;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (!m_tvalid) begin
					m_tvalid <= 1'b1;
					m_tdata  <= {6'b0, total_q, area_q};
					m_tuser  <= vld_q;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
